@@ sv/pfa_pkg.sv @@
// Shared types and codes for the partition fit allocator.
// Used by pfa_cell and partition_fit_allocator; no dependencies.
`timescale 1ns / 1ps

package pfa_pkg;

   // Request opcodes carried on req_mode
   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_FIRST  = 2'd1,
      MODE_BEST   = 2'd2,
      MODE_WORST  = 2'd3
   } mode_type;

   // Result status codes carried on rsp_status
   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_NOFIT = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_UPDATE = 2'd2
   } state_type;

   // Control part of the search token that walks the cell row
   typedef struct packed {
      logic     active;
      mode_type mode;
   } scan_ctl_type;

endpackage

@@ sv/pfa_cell.sv @@
// One storage cell of the partition row: holds one partition size and
// updates the passing search token. Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_cell
   import pfa_pkg::*;
#(
   parameter int MAX_PARTS = 16,
   parameter int SIZE_BITS = 16,
   parameter int CELL_IDX  = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   // token from the left neighbor
   input  scan_ctl_type                    ctl_in,
   input  logic [SIZE_BITS-1:0]            req_in,
   input  logic                            hit_in,
   input  logic [$clog2(MAX_PARTS)-1:0]    idx_in,
   input  logic [SIZE_BITS-1:0]            best_in,
   // table occupancy and write port
   input  logic [$clog2(MAX_PARTS+1)-1:0]  count_in,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_PARTS)-1:0]    wr_idx,
   input  logic [SIZE_BITS-1:0]            wr_data,
   // token to the right neighbor
   output scan_ctl_type                    ctl_out,
   output logic [SIZE_BITS-1:0]            req_out,
   output logic                            hit_out,
   output logic [$clog2(MAX_PARTS)-1:0]    idx_out,
   output logic [SIZE_BITS-1:0]            best_out
);

   localparam int IDX_W = $clog2(MAX_PARTS);
   localparam int CNT_W = $clog2(MAX_PARTS + 1);

   logic [SIZE_BITS-1:0] part_ff;
   scan_ctl_type         ctl_ff;
   logic [SIZE_BITS-1:0] req_ff;
   logic                 hit_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [SIZE_BITS-1:0] best_ff;

   logic                 fits;
   logic                 better;
   logic                 take;

   // does this cell's partition win against the token so far
   always_comb begin
      fits = ctl_in.active && (CNT_W'(CELL_IDX) < count_in) && (part_ff >= req_in);
      case (ctl_in.mode)
         MODE_BEST:  better = part_ff < best_in;
         MODE_WORST: better = part_ff > best_in;
         default:    better = 1'b0;
      endcase
      take = fits && (!hit_in || better);
   end

   // stored partition size, written by append or allocation update
   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
         part_ff <= wr_data;
      end
   end

   // token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (take) begin
         hit_ff  <= 1'b1;
         idx_ff  <= IDX_W'(CELL_IDX);
         best_ff <= part_ff;
      end else begin
         hit_ff  <= hit_in;
         idx_ff  <= idx_in;
         best_ff <= best_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign req_out  = req_ff;
   assign hit_out  = hit_ff;
   assign idx_out  = idx_ff;
   assign best_out = best_ff;

endmodule

@@ sv/partition_fit_allocator.sv @@
// Allocation: the token walks the cell row one cell per cycle; at the exit
// the result is registered, then moved to the output. Append: the result is
// registered on acceptance. Next request taken once it reaches the output.
// A result waiting in the output register does not block acceptance.
// Synchronous reset empties the table (count zero) and clears all valids.
`timescale 1ns / 1ps

module partition_fit_allocator
   import pfa_pkg::*;
#(
   parameter int MAX_PARTS = 16,
   parameter int SIZE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_amount,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic [15:0] rsp_left_over
);

   localparam int IDX_W = $clog2(MAX_PARTS);
   localparam int CNT_W = $clog2(MAX_PARTS + 1);

   // search token chain; entry 0 is the launch, entry MAX_PARTS the exit
   scan_ctl_type         ctl_chain  [0:MAX_PARTS];
   logic [SIZE_BITS-1:0] req_chain  [0:MAX_PARTS];
   logic                 hit_chain  [0:MAX_PARTS];
   logic [IDX_W-1:0]     idx_chain  [0:MAX_PARTS];
   logic [SIZE_BITS-1:0] best_chain [0:MAX_PARTS];

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff;
   logic [SIZE_BITS-1:0] req_ff;
   status_type           pend_status_ff;
   logic                 pend_wr_ff;
   logic                 pend_append_ff;
   logic [IDX_W-1:0]     pend_idx_ff;
   logic [SIZE_BITS-1:0] pend_size_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff;
   logic [3:0]           rsp_slot_ff;
   logic [15:0]          rsp_left_over_ff;

   logic [SIZE_BITS-1:0] amt;
   logic                 is_append;
   logic                 table_full;
   logic                 accept;
   logic                 out_free;
   logic                 scan_done;
   logic                 commit;

   assign amt        = SIZE_BITS'(32'(req_amount));
   assign is_append  = (mode_type'(req_mode) == MODE_APPEND);
   assign table_full = (count_ff == CNT_W'(MAX_PARTS));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scan_done  = ctl_chain[MAX_PARTS].active;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = is_append ? S_UPDATE : S_SCAN;
         end
         S_SCAN: begin
            if (scan_done) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      commit    = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_stall = 1'b0;
         S_SCAN:   req_stall = 1'b1;
         S_UPDATE: commit    = out_free;
         default:  req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   // token launch into the first cell
   always_comb begin
      ctl_chain[0].active = accept && !is_append;
      ctl_chain[0].mode   = mode_type'(req_mode);
      req_chain[0]        = amt;
      hit_chain[0]        = 1'b0;
      idx_chain[0]        = '0;
      best_chain[0]       = '0;
   end

   // row of partition cells
   for (genvar g = 0; g < MAX_PARTS; g++) begin : g_cell
      pfa_cell #(
         .MAX_PARTS (MAX_PARTS),
         .SIZE_BITS (SIZE_BITS),
         .CELL_IDX  (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (ctl_chain[g]),
         .req_in   (req_chain[g]),
         .hit_in   (hit_chain[g]),
         .idx_in   (idx_chain[g]),
         .best_in  (best_chain[g]),
         .count_in (count_ff),
         .wr_en    (commit && pend_wr_ff),
         .wr_idx   (pend_idx_ff),
         .wr_data  (pend_size_ff),
         .ctl_out  (ctl_chain[g+1]),
         .req_out  (req_chain[g+1]),
         .hit_out  (hit_chain[g+1]),
         .idx_out  (idx_chain[g+1]),
         .best_out (best_chain[g+1])
      );
   end

   // control registers
   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit && pend_append_ff) count_ff <= count_ff + 1'b1;
      end
   end

   // pending result: set on append accept or at scan exit
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= amt;
      end
      if (accept && is_append) begin
         pend_append_ff <= !table_full;
         pend_wr_ff     <= !table_full;
         pend_status_ff <= table_full ? STAT_FULL : STAT_DONE;
         pend_idx_ff    <= table_full ? '0 : count_ff[IDX_W-1:0];
         pend_size_ff   <= table_full ? '0 : amt;
      end else if ((state_ff == S_SCAN) && scan_done) begin
         pend_append_ff <= 1'b0;
         pend_wr_ff     <= hit_chain[MAX_PARTS];
         pend_status_ff <= hit_chain[MAX_PARTS] ? STAT_DONE : STAT_NOFIT;
         pend_idx_ff    <= hit_chain[MAX_PARTS] ? idx_chain[MAX_PARTS] : '0;
         pend_size_ff   <= hit_chain[MAX_PARTS] ? best_chain[MAX_PARTS] - req_ff : '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff    <= pend_status_ff;
         rsp_slot_ff      <= 4'(32'(pend_idx_ff));
         rsp_left_over_ff <= 16'(32'(pend_size_ff));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_left_over = rsp_left_over_ff;

endmodule

@@ sv/pfa_checker.sv @@
// Port-level checks for partition_fit_allocator, attached by bind.
// Sees only the top-level ports; depends on pfa_pkg for the status codes.
`timescale 1ns / 1ps

module pfa_checker
   import pfa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_mode,
   input logic [15:0] req_amount,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_slot,
   input logic [15:0] rsp_left_over
);

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_slot) && $stable(rsp_left_over))
      else $error("stalled response changed");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STAT_DONE || rsp_status == STAT_NOFIT
         || rsp_status == STAT_FULL)
      else $error("undefined response status");

   // failures report slot and leftover as zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_NOFIT || rsp_status == STAT_FULL)
         |-> rsp_slot == 4'd0 && rsp_left_over == 16'd0)
      else $error("failure response carries nonzero fields");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (.*);

@@ tb/partition_fit_allocator_test.sv @@
// Self-checking testbench for partition_fit_allocator: appends and
// first/best/worst fit allocations, checked against an in-bench table model.
// Depends on pfa_pkg and partition_fit_allocator.
`timescale 1ns / 1ps

module partition_fit_allocator_test
   import pfa_pkg::*;
();

   localparam int TABLE_DEPTH = 16;
   localparam int IDLE_LIMIT  = 4000;   // cycles with no transaction on either side
   localparam int DRAIN_PAD   = 40;     // well above the allocation latency

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_APPEND;
   logic [15:0] req_amount = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_slot;
   logic [15:0] rsp_left_over;

   typedef struct {
      status_type  status;
      logic [3:0]  slot;
      logic [15:0] left_over;
   } grant_type;

   // Mirror of the partition table plus the queue of results still owed
   class partition_ledger;
      logic [15:0] sizes [TABLE_DEPTH];
      int          count;
      grant_type   owed_grants [$];
      int          errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      function int pending();
         return owed_grants.size();
      endfunction

      // Apply one accepted request to the table and queue its result
      function void record_request(mode_type op, logic [15:0] amt);
         grant_type g;
         int        pick;
         int        key;
         g.status    = STAT_DONE;
         g.slot      = 4'd0;
         g.left_over = 16'd0;
         if (op == MODE_APPEND) begin
            if (count >= TABLE_DEPTH) begin
               g.status = STAT_FULL;
            end else begin
               sizes[count] = amt;
               g.slot       = 4'(count);
               g.left_over  = amt;
               count++;
            end
         end else begin
            pick = -1;
            key  = 0;
            for (int i = 0; i < count; i++) begin
               if (sizes[i] >= amt) begin
                  case (op)
                     MODE_FIRST: begin
                        if (pick < 0) pick = i;
                     end
                     MODE_BEST: begin
                        // strict compare keeps the lowest index on a tie
                        if (pick < 0 || int'(sizes[i]) - int'(amt) < key) begin
                           pick = i;
                           key  = int'(sizes[i]) - int'(amt);
                        end
                     end
                     default: begin
                        if (pick < 0 || int'(sizes[i]) > key) begin
                           pick = i;
                           key  = int'(sizes[i]);
                        end
                     end
                  endcase
               end
            end
            if (pick < 0) begin
               g.status = STAT_NOFIT;
            end else begin
               sizes[pick] = sizes[pick] - amt;
               g.slot      = 4'(pick);
               g.left_over = sizes[pick];
            end
         end
         owed_grants.push_back(g);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // Match one accepted result against the oldest owed one
      function void check_response(logic [1:0] st, logic [3:0] slot, logic [15:0] rest);
         grant_type g;
         if (owed_grants.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d slot %0d left %0d",
                     $time, st, slot, rest);
            errors++;
         end else begin
            g = owed_grants.pop_front();
            compare_field("status", 16'(g.status), 16'(st));
            compare_field("slot", 16'(g.slot), 16'(slot));
            compare_field("left_over", g.left_over, rest);
         end
      endfunction
   endclass

   partition_ledger ledger;
   int unsigned     idle_cycles = 0;
   int unsigned     stall_pct = 0;
   int unsigned     stall_left = 0;

   partition_fit_allocator uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_amount    (req_amount),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_left_over (rsp_left_over)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: stall probability is redrawn when its hold counter runs out, zero included
   always @(posedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(3))
            0: stall_pct <= 0;
            1: stall_pct <= 25;
            2: stall_pct <= 60;
            default: stall_pct <= 90;
         endcase
         stall_left <= $urandom_range(300, 50);
      end else begin
         stall_left <= stall_left - 1;
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Monitor: results first, since a result never belongs to a same-edge request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            ledger.check_response(rsp_status, rsp_slot, rsp_left_over);
         if (req_valid && !req_stall)
            ledger.record_request(mode_type'(req_mode), req_amount);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // One transaction; returns right after the accepting edge
   task automatic send(mode_type op, logic [15:0] amt);
      req_valid  <= 1'b1;
      req_mode   <= op;
      req_amount <= amt;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic idle(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off until every owed result has been seen
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // Request sizes biased toward small values so the table drains slowly
   function automatic logic [15:0] pick_request_size();
      int unsigned roll;
      logic [15:0] some;
      logic [15:0] biggest;
      roll = $urandom_range(99);
      if (ledger.count == 0) return 16'($urandom_range(255));
      some    = ledger.sizes[$urandom_range(ledger.count - 1)];
      biggest = 16'd0;
      for (int i = 0; i < ledger.count; i++)
         if (ledger.sizes[i] > biggest) biggest = ledger.sizes[i];
      if (roll < 3) return 16'd0;
      else if (roll < 7) return some;
      else if (roll < 11) return some + 16'd1;
      else if (roll < 16) return 16'($urandom_range(biggest));
      else if (roll < 30) return 16'($urandom);
      else return 16'($urandom_range(255));
   endfunction

   task automatic run_random(int unsigned items);
      int unsigned burst;
      burst = $urandom_range(30, 1);
      for (int unsigned k = 0; k < items; k++) begin
         if (k == items / 2) wait_drained();
         if ($urandom_range(99) < 8)
            send(MODE_APPEND, $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4096)));
         else
            send(mode_type'($urandom_range(3, 1)), pick_request_size());
         burst--;
         if (burst == 0) begin
            idle($urandom_range(12, 1));
            burst = $urandom_range(30, 1);
         end
      end
   endtask

   initial begin
      ledger = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: every policy misses
      send(MODE_FIRST, 16'd0);
      send(MODE_BEST, 16'd5);
      send(MODE_WORST, 16'hFFFF);
      // zero request fits a zero-size partition
      send(MODE_APPEND, 16'd0);
      send(MODE_FIRST, 16'd0);
      send(MODE_APPEND, 16'd100);
      send(MODE_APPEND, 16'd300);
      send(MODE_APPEND, 16'd100);
      send(MODE_APPEND, 16'd300);
      send(MODE_APPEND, 16'hFFFF);
      // best fit tie on an exact match, then a plain best fit
      send(MODE_BEST, 16'd100);
      send(MODE_BEST, 16'd50);
      // worst fit takes the full-size entry, then ties between equal ones
      send(MODE_WORST, 16'hFFFF);
      send(MODE_WORST, 16'd1);
      send(MODE_FIRST, 16'd40);
      send(MODE_FIRST, 16'hFFFF);
      send(MODE_WORST, 16'd0);
      send(MODE_BEST, 16'd0);
      wait_drained();

      run_random(1800);

      wait_drained();
      repeat (DRAIN_PAD) @(posedge clock);
      if (ledger.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
